// ----- design/dfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dfr_pkg: shared definitions for the delimited frame receiver
// Field widths, delimiter bytes, frame layout constants and event codes.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int BUF_DEPTH_DEF = 64;
	localparam int MAX_RESULTS   = 64;

	localparam int W_BYTE  = 8;
	localparam int W_KIND  = 3;
	localparam int W_WORD  = 16;
	localparam int W_SKIP  = 7;

	// short report frame delimiters
	localparam logic [7:0] REPORT_HEAD = 8'h6E;
	localparam logic [7:0] REPORT_TAIL = 8'h62;

	// four-byte delimiters, first byte on the wire first
	localparam logic [7:0] CMD_HEAD [4] = '{8'hFD, 8'hFC, 8'hFB, 8'hFA};
	localparam logic [7:0] CMD_FOOT [4] = '{8'h04, 8'h03, 8'h02, 8'h01};
	localparam logic [7:0] CAL_HEAD [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
	localparam logic [7:0] CAL_FOOT [4] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

	// response: header(4) length(2) command(2) status(2) data footer(4)
	localparam int RESP_OVERHEAD = 10;
	localparam int RESP_MIN_LEN  = 14;
	localparam int RESP_LEN_OFS  = 4;

	typedef enum logic [W_KIND-1:0] {
		K_REPORT     = 3'd0,
		K_CMD        = 3'd1,
		K_CAL        = 3'd2,
		K_CMD_NOHDR  = 3'd3,
		K_CAL_NOHDR  = 3'd4,
		K_RESP_SHORT = 3'd5,
		K_OVERFLOW   = 3'd6
	} kind_t;

endpackage

// ----- design/dfr_if.sv -----
// ----------------------------------------------------------------------------
// dfr_if: valid/ready channels of the delimited frame receiver
// Byte input channel and event result channel.
// ----------------------------------------------------------------------------
interface dfr_in_if;
	import dfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [W_BYTE-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
	import dfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [W_KIND-1:0] event_kind;
	logic [W_BYTE-1:0] report_state;
	logic [W_WORD-1:0] report_distance;
	logic [W_WORD-1:0] resp_command;
	logic [W_WORD-1:0] resp_status;
	logic              length_mismatch;
	logic [W_SKIP-1:0] skipped_bytes;
	logic [W_BYTE-1:0] data_byte;
	logic              data_valid;
	logic              last;

	modport source (
		output valid, input ready,
		output event_kind, output report_state, output report_distance,
		output resp_command, output resp_status, output length_mismatch,
		output skipped_bytes, output data_byte, output data_valid, output last
	);
	modport sink (
		input valid, output ready,
		input event_kind, input report_state, input report_distance,
		input resp_command, input resp_status, input length_mismatch,
		input skipped_bytes, input data_byte, input data_valid, input last
	);
endinterface

// ----- design/delimited_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// delimited_frame_receiver_core: header/footer deframer for serial bytes
// Buffers bytes, recognizes report, command response and calibration frames
// and emits one or more event results per recognized frame.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  rx      | in  | valid/ready  | rx_byte
//  result  | out | valid/ready  | event_kind .. data_valid, last
//
// A byte is written to the buffer on its transfer; the next cycle classifies
// the buffer tail. Header and payload bytes come through the single buffer
// read port, one at a time: each read state (S_HDR_RD, S_DATA_RD) is followed
// by its capture state (S_HDR_CAP, S_DATA_CAP).
// rx.ready is high only while the sequencer is idle; a finished result may
// still wait in the output register then. Output stalls hold the sequencer.
// Reset (arst_n) empties the buffer at once; buffer contents need no clearing.
module delimited_frame_receiver_core #(
	parameter int BUF_DEPTH = dfr_pkg::BUF_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dfr_in_if.sink    rx,
	dfr_out_if.source result
);
	import dfr_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = $clog2(BUF_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_EVAL, S_HDR_RD, S_HDR_CAP, S_EMPTY, S_DATA_RD, S_DATA_CAP
	} state_t;

	typedef struct packed {
		kind_t             kind;
		logic [W_BYTE-1:0] st;
		logic [W_WORD-1:0] distance;
		logic [W_WORD-1:0] cmd;
		logic [W_WORD-1:0] sts;
		logic              mism;
		logic [W_SKIP-1:0] skip;
		logic [W_BYTE-1:0] data;
		logic              dv;
		logic              last;
	} res_t;

	state_t            state_q;
	logic [CW-1:0]     fill_q;
	logic [7:0]        tail_q [5];
	logic [W_BYTE-1:0] mem [BUF_DEPTH];
	logic [W_BYTE-1:0] rdata_q;
	logic [AW-1:0]     addr_q;
	logic              chv_q, lhv_q;
	logic [AW-1:0]     chp_q, lhp_q;
	logic [2:0]        hcnt_q;
	logic [8:0]        actual_q;
	logic [6:0]        rem_q;
	logic [W_SKIP-1:0] skip_q;
	kind_t             kind_q;
	logic [W_BYTE-1:0] dl_lo_q;
	logic [W_WORD-1:0] cmd_q, sts_q;
	logic              mism_q;
	res_t              res_q;
	logic              ov_q;

	logic       acc, slot_free, res_load;
	logic       is_rep, is_cf, is_lf, is_ch, is_lh, is_ovf;
	logic [8:0] n9, cmd_flen9, cal_flen9;

	function automatic logic [W_SKIP-1:0] sat7(input logic [8:0] v);
		return (v > 9'd127) ? 7'd127 : v[6:0];
	endfunction

	function automatic logic [6:0] cap64(input logic [8:0] v);
		return (v > 9'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : v[6:0];
	endfunction

	function automatic logic match4(input logic [7:0] t3, input logic [7:0] t2,
			input logic [7:0] t1, input logic [7:0] t0, input logic [7:0] p [4]);
		return t3 == p[0] && t2 == p[1] && t1 == p[2] && t0 == p[3];
	endfunction

	assign rx.ready  = (state_q == S_IDLE);
	assign acc       = rx.valid && rx.ready;
	assign slot_free = !ov_q || result.ready;

	assign n9        = 9'(fill_q);
	assign cmd_flen9 = n9 - 9'(chp_q);
	assign cal_flen9 = n9 - 9'(lhp_q);

	assign is_rep = fill_q >= CW'(5) && tail_q[4] == REPORT_HEAD
		&& tail_q[0] == REPORT_TAIL;
	assign is_cf  = fill_q >= CW'(4)
		&& match4(tail_q[3], tail_q[2], tail_q[1], tail_q[0], CMD_FOOT);
	assign is_lf  = fill_q >= CW'(4)
		&& match4(tail_q[3], tail_q[2], tail_q[1], tail_q[0], CAL_FOOT);
	assign is_ch  = fill_q >= CW'(4)
		&& match4(tail_q[3], tail_q[2], tail_q[1], tail_q[0], CMD_HEAD);
	assign is_lh  = fill_q >= CW'(4)
		&& match4(tail_q[3], tail_q[2], tail_q[1], tail_q[0], CAL_HEAD);
	assign is_ovf = fill_q == CW'(BUF_DEPTH);

	// a new result enters the output register this cycle
	always_comb begin
		res_load = 1'b0;
		case (state_q)
			S_EVAL: begin
				if (is_rep) begin
					res_load = slot_free;
				end else if (is_cf) begin
					res_load = slot_free && !(chv_q && cmd_flen9 >= 9'(RESP_MIN_LEN));
				end else if (is_lf) begin
					res_load = slot_free && !lhv_q;
				end else if (is_ovf) begin
					res_load = slot_free;
				end
			end
			S_EMPTY, S_DATA_CAP: begin
				res_load = slot_free;
			end
			default: ;
		endcase
	end

	// buffer memory: write on byte transfer, registered read in read states
	always_ff @(posedge clk) begin
		if (acc) begin
			mem[fill_q[AW-1:0]] <= rx.rx_byte;
		end
		if (state_q == S_HDR_RD || state_q == S_DATA_RD) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tail_q[0] <= rx.rx_byte;
			for (int i = 1; i < 5; i++) begin
				tail_q[i] <= tail_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			chv_q   <= 1'b0;
			lhv_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && result.ready && !res_load) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						fill_q  <= fill_q + CW'(1);
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (is_rep) begin
						if (slot_free) begin
							res_q <= '{K_REPORT, tail_q[3], {tail_q[1], tail_q[2]},
								'0, '0, 1'b0, sat7(n9 - 9'd5), '0, 1'b0, 1'b1};
							ov_q    <= 1'b1;
							fill_q  <= '0;
							chv_q   <= 1'b0;
							lhv_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end else if (is_cf) begin
						if (chv_q && cmd_flen9 >= 9'(RESP_MIN_LEN)) begin
							addr_q   <= chp_q + AW'(RESP_LEN_OFS);
							hcnt_q   <= '0;
							actual_q <= cmd_flen9 - 9'(RESP_OVERHEAD);
							rem_q    <= cap64(cmd_flen9 - 9'(RESP_MIN_LEN));
							skip_q   <= sat7(9'(chp_q));
							kind_q   <= K_CMD;
							fill_q   <= '0;
							chv_q    <= 1'b0;
							lhv_q    <= 1'b0;
							state_q  <= S_HDR_RD;
						end else if (slot_free) begin
							if (chv_q) begin
								res_q <= '{K_RESP_SHORT, '0, '0, '0, '0, 1'b0,
									sat7(9'(chp_q)), '0, 1'b0, 1'b1};
							end else begin
								res_q <= '{K_CMD_NOHDR, '0, '0, '0, '0, 1'b0, '0,
									'0, 1'b0, 1'b1};
							end
							ov_q    <= 1'b1;
							fill_q  <= '0;
							chv_q   <= 1'b0;
							lhv_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end else if (is_lf) begin
						if (lhv_q) begin
							addr_q  <= lhp_q;
							rem_q   <= cap64(cal_flen9);
							skip_q  <= sat7(9'(lhp_q));
							kind_q  <= K_CAL;
							cmd_q   <= '0;
							sts_q   <= '0;
							mism_q  <= 1'b0;
							fill_q  <= '0;
							chv_q   <= 1'b0;
							lhv_q   <= 1'b0;
							state_q <= S_DATA_RD;
						end else if (slot_free) begin
							res_q <= '{K_CAL_NOHDR, '0, '0, '0, '0, 1'b0, '0,
								'0, 1'b0, 1'b1};
							ov_q    <= 1'b1;
							fill_q  <= '0;
							chv_q   <= 1'b0;
							lhv_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end else if (is_ovf) begin
						if (slot_free) begin
							res_q <= '{K_OVERFLOW, '0, '0, '0, '0, 1'b0, '0,
								'0, 1'b0, 1'b1};
							ov_q    <= 1'b1;
							fill_q  <= '0;
							chv_q   <= 1'b0;
							lhv_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end else begin
						// remember where the latest complete header starts
						if (is_ch) begin
							chv_q <= 1'b1;
							chp_q <= AW'(fill_q - CW'(4));
						end
						if (is_lh) begin
							lhv_q <= 1'b1;
							lhp_q <= AW'(fill_q - CW'(4));
						end
						state_q <= S_IDLE;
					end
				end
				S_HDR_RD: begin
					state_q <= S_HDR_CAP;
				end
				S_HDR_CAP: begin
					case (hcnt_q)
						3'd0: dl_lo_q <= rdata_q;
						3'd1: mism_q <= {rdata_q, dl_lo_q} != 16'(actual_q);
						3'd2: cmd_q[7:0] <= rdata_q;
						3'd3: cmd_q[15:8] <= rdata_q;
						3'd4: sts_q[7:0] <= rdata_q;
						3'd5: sts_q[15:8] <= rdata_q;
						default: ;
					endcase
					addr_q <= addr_q + AW'(1);
					hcnt_q <= hcnt_q + 3'd1;
					if (hcnt_q == 3'd5) begin
						state_q <= (rem_q == '0) ? S_EMPTY : S_DATA_RD;
					end else begin
						state_q <= S_HDR_RD;
					end
				end
				S_EMPTY: begin
					if (slot_free) begin
						res_q <= '{K_CMD, '0, '0, cmd_q, sts_q, mism_q, skip_q,
							'0, 1'b0, 1'b1};
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DATA_RD: begin
					state_q <= S_DATA_CAP;
				end
				S_DATA_CAP: begin
					// hold the fetched byte until the output register frees up
					if (slot_free) begin
						res_q <= '{kind_q, '0, '0, cmd_q, sts_q, mism_q, skip_q,
							rdata_q, 1'b1, rem_q == 7'd1};
						ov_q    <= 1'b1;
						rem_q   <= rem_q - 7'd1;
						addr_q  <= addr_q + AW'(1);
						state_q <= (rem_q == 7'd1) ? S_IDLE : S_DATA_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid           = ov_q;
	assign result.event_kind      = res_q.kind;
	assign result.report_state    = res_q.st;
	assign result.report_distance = res_q.distance;
	assign result.resp_command    = res_q.cmd;
	assign result.resp_status     = res_q.sts;
	assign result.length_mismatch = res_q.mism;
	assign result.skipped_bytes   = res_q.skip;
	assign result.data_byte       = res_q.data;
	assign result.data_valid      = res_q.dv;
	assign result.last            = res_q.last;

`ifndef ASSERT_OFF
	a_fill_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> fill_q < CW'(BUF_DEPTH))
		else $error("buffer full while waiting for a byte");

	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last |-> state_q != S_IDLE)
		else $error("run ended without a last result");

	a_data_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data_valid
		|-> result.event_kind == K_CMD || result.event_kind == K_CAL)
		else $error("data byte on an event without payload");

	a_no_rx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DATA_CAP || state_q == S_HDR_CAP |-> rem_q <= 7'(MAX_RESULTS))
		else $error("emission count beyond result limit");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for delimited_frame_receiver_core
// Streams serial bytes as report, command response and calibration frames,
// orphan footers, short responses and noise into the receiver. A local
// deframer predicts every event, and each result transfer is checked
// against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dfr_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 12;
	localparam int DEPTH        = BUF_DEPTH_DEF;
	localparam int RANDOM_BYTES = 40;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 5000000;

	// delimiters packed first byte on the wire in the top bits
	localparam logic [31:0] CMD_HEAD_W = {CMD_HEAD[0], CMD_HEAD[1], CMD_HEAD[2], CMD_HEAD[3]};
	localparam logic [31:0] CMD_FOOT_W = {CMD_FOOT[0], CMD_FOOT[1], CMD_FOOT[2], CMD_FOOT[3]};
	localparam logic [31:0] CAL_HEAD_W = {CAL_HEAD[0], CAL_HEAD[1], CAL_HEAD[2], CAL_HEAD[3]};
	localparam logic [31:0] CAL_FOOT_W = {CAL_FOOT[0], CAL_FOOT[1], CAL_FOOT[2], CAL_FOOT[3]};

	typedef struct {
		kind_t             kind;
		logic [W_BYTE-1:0] state;
		logic [W_WORD-1:0] distance;
		logic [W_WORD-1:0] command;
		logic [W_WORD-1:0] status;
		logic              mismatch;
		logic [W_SKIP-1:0] skipped;
		logic [W_BYTE-1:0] data;
		logic              dvalid;
		logic              last;
	} frame_event_t;

	logic clk = 1'b0;
	logic arst_n;

	dfr_in_if  byte_ch ();
	dfr_out_if event_ch ();

	delimited_frame_receiver_core #(.BUF_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (byte_ch),
		.result (event_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	logic [W_BYTE-1:0] line_buf [DEPTH];
	int                line_fill;
	frame_event_t      pending_events [$];
	int                errors = 0;
	int                bytes_sent = 0;
	int                cycles = 0;
	int                out_stall = 0;
	bit                calm = 1'b1;

	// ------------------------------------------------------------------------
	// deframer prediction
	// ------------------------------------------------------------------------
	function automatic bit mark_at(input int pos, input logic [31:0] m);
		return {line_buf[pos], line_buf[pos+1], line_buf[pos+2], line_buf[pos+3]} == m;
	endfunction

	// last start position of m lying wholly below len, -1 if none
	function automatic int last_mark(input int len, input logic [31:0] m);
		for (int i = len - 4; i >= 0; i--)
			if (mark_at(i, m))
				return i;
		return -1;
	endfunction

	function automatic frame_event_t blank_event(input kind_t k, input int skip);
		frame_event_t ev;
		ev.kind     = k;
		ev.state    = '0;
		ev.distance = '0;
		ev.command  = '0;
		ev.status   = '0;
		ev.mismatch = 1'b0;
		ev.skipped  = (skip > 127) ? 7'd127 : skip[W_SKIP-1:0];
		ev.data     = '0;
		ev.dvalid   = 1'b0;
		ev.last     = 1'b1;
		return ev;
	endfunction

	function automatic void deframe_byte(input logic [W_BYTE-1:0] b);
		frame_event_t ev;
		int n, p, flen, actual, cnt;
		logic [W_WORD-1:0] declared;
		if (line_fill >= DEPTH)
			line_fill = 0;
		line_buf[line_fill] = b;
		line_fill++;
		n = line_fill;

		if (n >= 5 && line_buf[n-5] == REPORT_HEAD && line_buf[n-1] == REPORT_TAIL) begin
			ev = blank_event(K_REPORT, n - 5);
			ev.state    = line_buf[n-4];
			ev.distance = {line_buf[n-2], line_buf[n-3]};
			pending_events.push_back(ev);
			line_fill = 0;
			return;
		end

		if (n >= 4 && mark_at(n - 4, CMD_FOOT_W)) begin
			line_fill = 0;
			p = last_mark(n - 4, CMD_HEAD_W);
			if (p < 0) begin
				pending_events.push_back(blank_event(K_CMD_NOHDR, 0));
				return;
			end
			flen = n - p;
			if (flen < RESP_MIN_LEN) begin
				pending_events.push_back(blank_event(K_RESP_SHORT, p));
				return;
			end
			declared    = {line_buf[p+RESP_LEN_OFS+1], line_buf[p+RESP_LEN_OFS]};
			actual      = flen - RESP_OVERHEAD;
			ev          = blank_event(K_CMD, p);
			ev.mismatch = (int'(declared) != actual);
			ev.command  = {line_buf[p+7], line_buf[p+6]};
			ev.status   = {line_buf[p+9], line_buf[p+8]};
			if (actual == 4) begin
				pending_events.push_back(ev);
				return;
			end
			cnt = (actual - 4 > MAX_RESULTS) ? MAX_RESULTS : actual - 4;
			for (int i = 0; i < cnt; i++) begin
				ev.data   = line_buf[p+RESP_OVERHEAD+i];
				ev.dvalid = 1'b1;
				ev.last   = (i == cnt - 1);
				pending_events.push_back(ev);
			end
			return;
		end

		if (n >= 4 && mark_at(n - 4, CAL_FOOT_W)) begin
			line_fill = 0;
			p = last_mark(n - 4, CAL_HEAD_W);
			if (p < 0) begin
				pending_events.push_back(blank_event(K_CAL_NOHDR, 0));
				return;
			end
			flen = n - p;
			cnt  = (flen > MAX_RESULTS) ? MAX_RESULTS : flen;
			ev   = blank_event(K_CAL, p);
			for (int i = 0; i < cnt; i++) begin
				ev.data   = line_buf[p+i];
				ev.dvalid = 1'b1;
				ev.last   = (i == cnt - 1);
				pending_events.push_back(ev);
			end
			return;
		end

		if (n >= DEPTH) begin
			line_fill = 0;
			pending_events.push_back(blank_event(K_OVERFLOW, 0));
		end
	endfunction

	// ------------------------------------------------------------------------
	// idling, stimulus
	// ------------------------------------------------------------------------
	// mostly none, often short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [W_BYTE-1:0] rand_byte();
		return W_BYTE'($urandom_range(0, 255));
	endfunction

	function automatic logic [W_WORD-1:0] rand_word();
		return W_WORD'($urandom_range(0, 65535));
	endfunction

	task automatic send_byte(input logic [W_BYTE-1:0] b);
		int gap;
		gap = calm ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.rx_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [W_WORD-1:0] w);
		send_byte(w[7:0]);
		send_byte(w[15:8]);
	endtask

	task automatic send_mark(input logic [31:0] m);
		for (int i = 3; i >= 0; i--)
			send_byte(m[i*8 +: 8]);
	endtask

	task automatic send_junk(input int count, input logic [W_BYTE-1:0] b);
		repeat (count) send_byte(b);
	endtask

	task automatic send_report(input logic [W_BYTE-1:0] state,
			input logic [W_WORD-1:0] distance);
		send_byte(REPORT_HEAD);
		send_byte(state);
		send_word(distance);
		send_byte(REPORT_TAIL);
	endtask

	task automatic send_response(input int payload_cnt, input logic [W_WORD-1:0] declared,
			input logic [W_WORD-1:0] command, input logic [W_WORD-1:0] status);
		send_mark(CMD_HEAD_W);
		send_word(declared);
		send_word(command);
		send_word(status);
		repeat (payload_cnt) send_byte(rand_byte());
		send_mark(CMD_FOOT_W);
	endtask

	task automatic send_short_response(input int body_len);
		send_mark(CMD_HEAD_W);
		repeat (body_len) send_byte(rand_byte());
		send_mark(CMD_FOOT_W);
	endtask

	task automatic send_calibration(input int body_len);
		send_mark(CAL_HEAD_W);
		repeat (body_len) send_byte(rand_byte());
		send_mark(CAL_FOOT_W);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_reports();
		calm = 1'b1;
		send_report(8'h00, 16'h0000);
		send_junk(3, 8'h30);
		send_report(8'hFF, 16'hFFFF);
	endtask

	task automatic test_responses();
		calm = 1'b0;
		send_response(3, 16'd7, 16'hFFFF, 16'h0000);
		send_response(0, 16'd4, 16'h0000, 16'hFFFF);
		send_response(2, 16'hFFFF, 16'h1234, 16'h5678);
		send_junk(2, 8'h11);
		send_short_response(1);
		send_mark(CMD_FOOT_W);
	endtask

	task automatic test_calibration();
		send_calibration(5);
		send_calibration(0);
		send_mark(CAL_FOOT_W);
	endtask

	task automatic test_buffer_limits();
		send_junk(DEPTH, 8'h55);
		// frames that end exactly as the buffer fills
		send_calibration(DEPTH - 8);
		send_response(DEPTH - 14, 16'(DEPTH - 10), 16'hA5C3, 16'h3C5A);
	endtask

	task automatic test_random_traffic();
		int start, sel, len;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0)
				calm = ~calm;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 6)) send_byte(rand_byte());
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				send_report(rand_byte(), rand_word());
			end else if (sel < 50) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
				send_response(len, ($urandom_range(0, 4) == 0) ? rand_word() : 16'(len + 4),
					rand_word(), rand_word());
			end else if (sel < 68) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				send_calibration(len);
			end else if (sel < 76) begin
				send_short_response($urandom_range(0, 5));
			end else if (sel < 84) begin
				send_mark($urandom_range(0, 1) ? CMD_FOOT_W : CAL_FOOT_W);
			end else if (sel < 92) begin
				// header with no footer: lingers in the buffer
				send_mark($urandom_range(0, 1) ? CMD_HEAD_W : CAL_HEAD_W);
				repeat ($urandom_range(0, 6)) send_byte(rand_byte());
			end else begin
				len = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(5, 20);
				repeat (len) send_byte(rand_byte());
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------
	initial begin
		event_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_stall == 0 && !calm && $urandom_range(0, 3) == 0)
				out_stall = idle_len();
			if (out_stall > 0) begin
				event_ch.ready <= 1'b0;
				out_stall--;
			end else begin
				event_ch.ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		frame_event_t ev;
		if (arst_n && event_ch.valid && event_ch.ready) begin
			if (pending_events.size() == 0) begin
				$error("event_kind: expected none, got %0h", event_ch.event_kind);
				errors++;
			end else begin
				ev = pending_events.pop_front();
				check_field("event_kind", ev.kind, event_ch.event_kind);
				check_field("report_state", ev.state, event_ch.report_state);
				check_field("report_distance", ev.distance, event_ch.report_distance);
				check_field("resp_command", ev.command, event_ch.resp_command);
				check_field("resp_status", ev.status, event_ch.resp_status);
				check_field("length_mismatch", ev.mismatch, event_ch.length_mismatch);
				check_field("skipped_bytes", ev.skipped, event_ch.skipped_bytes);
				check_field("data_byte", ev.data, event_ch.data_byte);
				check_field("data_valid", ev.dvalid, event_ch.data_valid);
				check_field("last", ev.last, event_ch.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		byte_ch.valid   = 1'b0;
		byte_ch.rx_byte = '0;
		line_fill       = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_reports();
		test_responses();
		test_calibration();
		test_buffer_limits();
		test_random_traffic();

		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
design/dfr_pkg.sv
design/dfr_if.sv
design/delimited_frame_receiver_core.sv
tb/tb_top.sv
